// File: hdl/quaternion_normalize_defines.svh
// ---------------------------------------------------------------------------
// quaternion normalize assertion macros
// shared concurrent check forms, clocked on the rising edge, reset-gated
// ---------------------------------------------------------------------------
`ifndef QUATERNION_NORMALIZE_DEFINES_SVH
`define QUATERNION_NORMALIZE_DEFINES_SVH

// same-cycle implication
`define QN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/qn_pkg.sv
// ---------------------------------------------------------------------------
// quaternion normalize package
// widths, pipeline payload types and the per-step arithmetic
// ---------------------------------------------------------------------------
package qn_pkg;

   localparam int COMP_W       = 16;
   localparam int LANES        = 4;
   localparam int SQ_W         = 31;
   localparam int SUM_W        = 33;
   localparam int RAD_W        = 42;
   localparam int ROOT_W       = 21;
   localparam int SQ_REM_W     = 24;
   localparam int QUO_W        = 15;
   localparam int SQRT_STEPS   = 3;
   localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;
   localparam int DIV_STEPS    = 3;
   localparam int DIV_STAGES   = QUO_W / DIV_STEPS;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [COMP_W-1:0]     ONE_Q14       = 16'd16384;
   localparam logic [CSR_DATA_W-1:0] EPSILON_RESET = 32'd268;
   localparam logic                  REG_EPSILON   = 1'b0;

   typedef logic [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic                         valid;
      logic                         degen;
      logic [LANES-1:0][COMP_W-1:0] comp;
      logic [RAD_W-1:0]             rad;
      logic [SQ_REM_W-1:0]          rem;
      logic [ROOT_W-1:0]            root;
   } sqrt_pipe_type;

   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [ROOT_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } div_lane_type;

   typedef struct packed {
      logic                        valid;
      logic                        degen;
      logic [ROOT_W-1:0]           len;
      div_lane_type [LANES-1:0]    lane;
   } div_pipe_type;

   // one radicand digit pair of the bit-by-bit square root
   function automatic sqrt_pipe_type sqrt_step(input sqrt_pipe_type s);
      sqrt_pipe_type       r;
      logic [SQ_REM_W-1:0] rem2;
      logic [SQ_REM_W-1:0] trial;
      r     = s;
      rem2  = {s.rem[SQ_REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = rem2 - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem2;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // one quotient bit of the restoring divide
   function automatic div_lane_type div_step(input div_lane_type l, input logic [ROOT_W-1:0] len);
      div_lane_type      r;
      logic [ROOT_W:0]   r2;
      logic [ROOT_W:0]   diff;
      r    = l;
      r2   = {l.rem, 1'b0};
      diff = r2 - {1'b0, len};
      if (r2 >= {1'b0, len}) begin
         r.rem = diff[ROOT_W-1:0];
         r.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = r2[ROOT_W-1:0];
         r.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: hdl/qn_if.sv
// ---------------------------------------------------------------------------
// quaternion normalize channels
// request and response handshake interfaces
// ---------------------------------------------------------------------------
interface qn_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] comp_x;
   logic signed [15:0] comp_y;
   logic signed [15:0] comp_z;
   logic signed [15:0] comp_w;

   modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface qn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] unit_x;
   logic signed [15:0] unit_y;
   logic signed [15:0] unit_z;
   logic signed [15:0] unit_w;
   logic               degenerate;

   modport source (output valid, unit_x, unit_y, unit_z, unit_w, degenerate, input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, degenerate, output ready);
endinterface

// File: hdl/quaternion_normalize.sv
// ---------------------------------------------------------------------------
// quaternion normalize
// scales a q2.14 quaternion to unit length in q1.14, identity when degenerate
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   req       in         valid / ready      comp_x comp_y comp_z comp_w
//   rsp       out        valid / ready      unit_x unit_y unit_z unit_w degenerate
//   csr       in         psel/penable apb   length_epsilon at byte address 0
//
// one beat per cycle sustained while the response is accepted; a request passes the
// registers (input, square, sum, 7 root stages, prep, 5 divide stages, output)
// the root loop (21 bits, 3 per stage) and the divide (15 bits, 3 per stage)
// set the depth; reset clears only the valid bits and the epsilon register
// a stalled response freezes the whole pipe, so nothing is dropped or repeated
//
`include "quaternion_normalize_defines.svh"

module quaternion_normalize (
   input  logic                          clock,
   input  logic                          reset,
   qn_req_if.sink                        req,
   qn_rsp_if.source                      rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [qn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [qn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [qn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import qn_pkg::*;

   logic [CSR_DATA_W-1:0] epsilon;
   logic                  advance;

   // input register
   logic                         in_valid_ff;
   logic [LANES-1:0][COMP_W-1:0] in_comp_ff;

   // squares
   logic                         sq_valid_ff;
   logic [LANES-1:0][COMP_W-1:0] sq_comp_ff;
   logic [LANES-1:0][SQ_W-1:0]   sq_ff;
   logic [LANES-1:0][SQ_W-1:0]   sq_in;

   // sum and degenerate test feed the root chain
   sqrt_pipe_type sum_ff;
   sqrt_pipe_type sum_in;
   sqrt_pipe_type sqrt_pipe [SQRT_STAGES+1];

   // divide chain
   div_pipe_type  prep_ff;
   div_pipe_type  prep_in;
   div_pipe_type  div_pipe [DIV_STAGES+1];

   // output register
   logic                         out_valid_ff;
   logic                         out_degen_ff;
   logic [LANES-1:0][COMP_W-1:0] out_unit_ff;
   logic [LANES-1:0][COMP_W-1:0] out_unit_in;

   qn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .epsilon (epsilon)
   );

   // whole pipe moves unless a finished beat waits at the output
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_comp_ff <= {req.comp_w, req.comp_z, req.comp_y, req.comp_x};
      end
   end

   // four signed squares, one multiplier each
   always_comb begin
      for (int n = 0; n < LANES; n++) begin
         sq_in[n] = SQ_W'($signed(in_comp_ff[n]) * $signed(in_comp_ff[n]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff      <= sq_in;
         sq_comp_ff <= in_comp_ff;
      end
   end

   // squared length, epsilon compare, radicand = sum << 8
   always_comb begin
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      sum_in.valid = sq_valid_ff;
      sum_in.degen = (sum == '0) || (sum < {1'b0, epsilon});
      sum_in.comp  = sq_comp_ff;
      sum_in.rad   = {1'b0, sum, 8'h00};
      sum_in.rem   = '0;
      sum_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
      end else if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign sqrt_pipe[0] = sum_ff;

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      qn_sqrt_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_pipe (sqrt_pipe[g]),
         .dn_pipe (sqrt_pipe[g+1])
      );
   end

   // magnitudes and overflow check; when |c|*8 < len the high quotient
   // bits are zero and the partial remainder starts at |c|*8
   always_comb begin
      logic [COMP_W-1:0] mag;
      logic [ROOT_W-1:0] mag8;
      prep_in.valid = sqrt_pipe[SQRT_STAGES].valid;
      prep_in.degen = sqrt_pipe[SQRT_STAGES].degen;
      prep_in.len   = sqrt_pipe[SQRT_STAGES].root;
      for (int n = 0; n < LANES; n++) begin
         prep_in.lane[n].neg = sqrt_pipe[SQRT_STAGES].comp[n][COMP_W-1];
         mag  = prep_in.lane[n].neg ? COMP_W'(0 - sqrt_pipe[SQRT_STAGES].comp[n])
                                    : sqrt_pipe[SQRT_STAGES].comp[n];
         mag8 = {2'b00, mag, 3'b000};
         prep_in.lane[n].ovf = (mag8 >= prep_in.len);
         prep_in.lane[n].rem = prep_in.lane[n].ovf ? '0 : mag8;
         prep_in.lane[n].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign div_pipe[0] = prep_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      qn_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_pipe (div_pipe[g]),
         .dn_pipe (div_pipe[g+1])
      );
   end

   // saturate at one, restore sign, identity for degenerate beats
   always_comb begin
      logic [COMP_W-1:0] qm;
      for (int n = 0; n < LANES; n++) begin
         qm = {1'b0, div_pipe[DIV_STAGES].lane[n].quo};
         if (div_pipe[DIV_STAGES].lane[n].ovf || (qm > ONE_Q14)) begin
            qm = ONE_Q14;
         end
         out_unit_in[n] = div_pipe[DIV_STAGES].lane[n].neg ? COMP_W'(0 - qm) : qm;
         if (div_pipe[DIV_STAGES].degen) begin
            out_unit_in[n] = (n == LANES - 1) ? ONE_Q14 : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_pipe[DIV_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_unit_ff  <= out_unit_in;
         out_degen_ff <= div_pipe[DIV_STAGES].degen;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.unit_x     = out_unit_ff[0];
   assign rsp.unit_y     = out_unit_ff[1];
   assign rsp.unit_z     = out_unit_ff[2];
   assign rsp.unit_w     = out_unit_ff[3];
   assign rsp.degenerate = out_degen_ff;

   // degenerate beats carry the identity quaternion
   `QN_ASSERT_SAME(a_degen_identity, clock, reset, rsp.valid && rsp.degenerate, (rsp.unit_x == 16'sd0) && (rsp.unit_y == 16'sd0) && (rsp.unit_z == 16'sd0) && (rsp.unit_w == 16'sd16384), "degenerate beat is not the identity")
   // normalized x and w components never exceed one in magnitude
   `QN_ASSERT_SAME(a_unit_range, clock, reset, rsp.valid, (rsp.unit_x <= 16'sd16384) && (rsp.unit_x >= -16'sd16384) && (rsp.unit_w <= 16'sd16384) && (rsp.unit_w >= -16'sd16384), "component beyond unit range")
   // a live beat entering the divider has a nonzero length
   `QN_ASSERT_SAME(a_len_nonzero, clock, reset, div_pipe[0].valid && !div_pipe[0].degen, div_pipe[0].len != '0, "zero length reached the divider")
   // a frozen pipe keeps its output register
   `QN_ASSERT_NEXT(a_freeze_holds, clock, reset, !advance, out_valid_ff && $stable(out_unit_ff), "output changed while pipe frozen")

endmodule

// File: hdl/qn_csr.sv
// ---------------------------------------------------------------------------
// quaternion normalize register file
// apb-style access to the squared-length epsilon
// ---------------------------------------------------------------------------
module qn_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [qn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [qn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [qn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output logic [qn_pkg::CSR_DATA_W-1:0] epsilon
);
   import qn_pkg::*;

   logic [CSR_DATA_W-1:0] epsilon_ff;
   logic [CSR_DATA_W-1:0] epsilon_in;

   always_comb begin
      epsilon_in = epsilon_ff;
      if (psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == REG_EPSILON)) begin
         epsilon_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPSILON_RESET;
      end else begin
         epsilon_ff <= epsilon_in;
      end
   end

   assign prdata  = (paddr[CSR_ADDR_W-1] == REG_EPSILON) ? epsilon_ff : '0;
   assign pready  = 1'b1;
   assign epsilon = epsilon_ff;

endmodule

// File: hdl/qn_sqrt_stage.sv
// ---------------------------------------------------------------------------
// quaternion normalize square root stage
// three root bits per register stage
// ---------------------------------------------------------------------------
module qn_sqrt_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  qn_pkg::sqrt_pipe_type up_pipe,
   output qn_pkg::sqrt_pipe_type dn_pipe
);
   import qn_pkg::*;

   sqrt_pipe_type pipe_ff;
   sqrt_pipe_type pipe_in;

   always_comb begin
      pipe_in = up_pipe;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         pipe_in = sqrt_step(pipe_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign dn_pipe = pipe_ff;

endmodule

// File: hdl/qn_div_stage.sv
// ---------------------------------------------------------------------------
// quaternion normalize divide stage
// three quotient bits per register stage on all four lanes
// ---------------------------------------------------------------------------
module qn_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  qn_pkg::div_pipe_type up_pipe,
   output qn_pkg::div_pipe_type dn_pipe
);
   import qn_pkg::*;

   div_pipe_type pipe_ff;
   div_pipe_type pipe_in;

   always_comb begin
      pipe_in = up_pipe;
      for (int n = 0; n < LANES; n++) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            pipe_in.lane[n] = div_step(pipe_in.lane[n], up_pipe.len);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign dn_pipe = pipe_ff;

endmodule
